// File: rtl/pcrc_pkg.sv
// Package for the packet CRC-16 append/check block.
// Holds the beat payload types, CRC constants and the byte fold function.
// No dependencies.
package pcrc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // Depth of the result queue and its pointer and count widths.
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned PTR_W     = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W     = $clog2(RSP_DEPTH + 1);
   // Most results that one input beat can push.
   localparam int unsigned MAX_PUSH  = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       verdict_valid;
      logic       crc_ok;
   } rsp_type;

   // Folds one byte into a reflected CRC-16, LSB first.
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/packet_crc16_append_check_top.sv
// Top level of the packet CRC-16 append/check block.
// Depends on pcrc_pkg for the beat types, CRC constants and the fold function.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    pcrc_pkg::req_type (data_byte, last_byte)
//   rsp      out        rsp_valid/stall    pcrc_pkg::rsp_type (out_byte, out_last,
//                                          verdict_valid, crc_ok)
//   csr      in         csr_valid/ready    csr_check_mode (1 bit)
//
// For each input beat, the CRC fold and the hold-buffer update happen
// combinationally between the state registers and a four-entry result queue.
// One beat per cycle is sustained while rsp_stall stays low; a generate-mode last
// byte pushes three results, so input then stalls until at most one result waits.
// req_stall comes from the registered queue fill level (high while more than one
// result waits) and from a mode write being taken, so there is no combinational
// path from rsp_stall to req_stall.
// Reset is synchronous and active high; it clears the mode, the CRC state and the
// queue. The csr port is ready only while the queue is empty, and the byte channel
// stalls in the cycle in which a mode write is taken.
module packet_crc16_append_check_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcrc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_check_mode
);

   // Mode and per-packet CRC state.
   logic        mode_ff, mode_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;

   // Result queue.
   pcrc_pkg::rsp_type               queue_ff [pcrc_pkg::RSP_DEPTH];
   logic [pcrc_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pcrc_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pcrc_pkg::CNT_W-1:0]      count_ff, count_in;

   // Results produced by the beat being accepted.
   pcrc_pkg::rsp_type               push_item [pcrc_pkg::MAX_PUSH];
   logic [1:0]                      push_num;

   logic        req_take;
   logic        rsp_take;
   logic        csr_write;
   logic [15:0] fold_in_crc;
   logic [7:0]  fold_byte;
   logic [15:0] fold_out;
   logic        verdict_ok;

   // A new beat is taken only while at most one result waits, so a three-result
   // burst always fits in the four-entry queue even if nothing drains. A mode
   // write takes the cycle for itself so that no byte beat is lost beside it.
   assign req_stall = reset || (count_ff > pcrc_pkg::CNT_W'(1)) || csr_write;
   assign csr_ready = !reset && (count_ff == '0);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_write = csr_valid && csr_ready;

   // One fold unit: generate mode folds the incoming byte, check mode folds the
   // oldest held byte once two bytes are already held.
   assign fold_in_crc = crc_ff;
   assign fold_byte   = mode_ff ? held0_ff : req_data.data_byte;
   assign fold_out    = pcrc_pkg::crc_fold(fold_in_crc, fold_byte);

   always_comb begin
      mode_in     = mode_ff;
      crc_in      = crc_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      held_cnt_in = held_cnt_ff;
      verdict_ok  = 1'b0;
      push_num    = 2'd0;
      for (int i = 0; i < pcrc_pkg::MAX_PUSH; i++) begin
         push_item[i] = '0;
      end

      if (csr_write) begin
         // A mode write abandons any packet in progress.
         mode_in     = csr_check_mode;
         crc_in      = pcrc_pkg::CRC_INIT;
         held0_in    = '0;
         held1_in    = '0;
         held_cnt_in = '0;
      end else if (req_take) begin
         if (!mode_ff) begin
            // Generate mode: pass the byte through, append the CRC at the end.
            crc_in                 = fold_out;
            push_item[0].out_byte  = req_data.data_byte;
            push_num               = 2'd1;
            if (req_data.last_byte) begin
               push_item[1].out_byte = fold_out[15:8];
               push_item[2].out_byte = fold_out[7:0];
               push_item[2].out_last = 1'b1;
               push_num              = 2'd3;
               crc_in                = pcrc_pkg::CRC_INIT;
               held0_in              = '0;
               held1_in              = '0;
               held_cnt_in           = '0;
            end
         end else begin
            // Check mode: keep the two newest bytes back from the CRC.
            if (held_cnt_ff >= 2'd2) begin
               crc_in   = fold_out;
               held0_in = held1_ff;
               held1_in = req_data.data_byte;
            end else begin
               if (held_cnt_ff[0]) begin
                  held1_in = req_data.data_byte;
               end else begin
                  held0_in = req_data.data_byte;
               end
               held_cnt_in = held_cnt_ff + 2'd1;
            end
            if (req_data.last_byte) begin
               verdict_ok = (held_cnt_in >= 2'd2) && (held0_in == crc_in[15:8]) &&
                            (held1_in == crc_in[7:0]);
               push_item[0].out_last      = 1'b1;
               push_item[0].verdict_valid = 1'b1;
               push_item[0].crc_ok        = verdict_ok;
               push_num                   = 2'd1;
               crc_in                     = pcrc_pkg::CRC_INIT;
               held0_in                   = '0;
               held1_in                   = '0;
               held_cnt_in                = '0;
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pcrc_pkg::PTR_W'(push_num);
      rd_ptr_in = rd_ptr_ff + pcrc_pkg::PTR_W'(rsp_take);
      count_in  = count_ff + pcrc_pkg::CNT_W'(push_num) - pcrc_pkg::CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         crc_ff      <= pcrc_pkg::CRC_INIT;
         held0_ff    <= '0;
         held1_ff    <= '0;
         held_cnt_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         mode_ff     <= mode_in;
         crc_ff      <= crc_in;
         held0_ff    <= held0_in;
         held1_ff    <= held1_in;
         held_cnt_ff <= held_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // Queue storage holds payload only; it needs no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < pcrc_pkg::MAX_PUSH; i++) begin
         if (i < int'(push_num)) begin
            queue_ff[wr_ptr_ff + pcrc_pkg::PTR_W'(i)] <= push_item[i];
         end
      end
   end

   // The queue never holds more results than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcrc_pkg::CNT_W'(pcrc_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // A generate-mode last byte leaves at least two results queued.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.last_byte && !mode_ff && !csr_write) |=>
         (count_ff >= pcrc_pkg::CNT_W'(2)))
      else $error("CRC append burst missing from queue");

   // The CRC and hold buffer restart after every packet end.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.last_byte && !csr_write) |=>
         (crc_ff == pcrc_pkg::CRC_INIT && held_cnt_ff == 2'd0))
      else $error("CRC state not cleared at packet end");

   // A mode write clears the packet state.
   assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (crc_ff == pcrc_pkg::CRC_INIT && held_cnt_ff == 2'd0))
      else $error("CRC state not cleared by mode write");

   // The hold buffer never counts past two bytes.
   assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd3)
      else $error("hold count out of range");

endmodule
